FILE: design/csb_pkg.sv
// ----------------------------------------------------------------------------
// csb_pkg
// Shared types, constants and helpers for the color keyed sprite blitter.
// ----------------------------------------------------------------------------
package csb_pkg;

  // Screen and sprite limits.
  localparam int H_RES      = 1024;
  localparam int V_RES      = 768;
  localparam int MAX_SPRITE = 1024;

  // Field widths.
  localparam int POS_W   = 12;   // origin registers, signed
  localparam int SIZE_W  = 11;   // sprite size registers
  localparam int COLOR_W = 16;
  localparam int IDX_W   = 20;   // framebuffer index

  // Derived widths.
  localparam int CNT_W  = $clog2(MAX_SPRITE);       // column and row counters
  localparam int CMP_W  = 14;                       // counter compare width
  localparam int CALC_W = 15;                       // signed screen coordinates
  localparam int LINE_W = $clog2(V_RES);
  localparam int COL_W  = $clog2(H_RES);
  localparam int PROD_W = LINE_W + COL_W + 2;

  // APB register map.
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_X   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Y   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_WIDTH      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ALIGN      = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_KEY_ENABLE = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_KEY_COLOR  = 3'd6;

  // Alignment codes.
  localparam logic [1:0] ALIGN_LEFT = 2'd0;
  localparam logic [1:0] ALIGN_MID  = 2'd1;
  localparam logic [1:0] ALIGN_END  = 2'd2;

  // Configuration as seen by the datapath; sizes are already clamped.
  typedef struct packed {
    logic signed [POS_W-1:0]   origin_x;
    logic signed [POS_W-1:0]   origin_y;
    logic [SIZE_W-1:0]         width_eff;
    logic [SIZE_W-1:0]         height_eff;
    logic [1:0]                align_mode;
    logic                      key_enable;
    logic [COLOR_W-1:0]        key_color;
  } cfg_t;

  // Position of one pixel inside the sprite.
  typedef struct packed {
    logic [CNT_W-1:0] col;
    logic [CNT_W-1:0] row;
    logic             done;
  } cursor_t;

  // One finished result.
  typedef struct packed {
    logic [IDX_W-1:0]   fb_index;
    logic [COLOR_W-1:0] fb_data;
    logic               write_enable;
    logic               sprite_done;
  } result_t;

  // A size of zero counts as one, and sizes above the limit saturate.
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (CMP_W'(v) > CMP_W'(MAX_SPRITE)) begin
      r = SIZE_W'(MAX_SPRITE);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

FILE: design/csb_regs.sv
// ----------------------------------------------------------------------------
// csb_regs
// APB register file holding the blit configuration.
// ----------------------------------------------------------------------------
module csb_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [csb_pkg::ADDR_W-1:0]   paddr,
  input  logic [csb_pkg::DATA_W-1:0]   pwdata,
  output logic [csb_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output csb_pkg::cfg_t                cfg
);

  logic [csb_pkg::POS_W-1:0]     origin_x;
  logic [csb_pkg::POS_W-1:0]     origin_y;
  logic [csb_pkg::SIZE_W-1:0]    sprite_width;
  logic [csb_pkg::SIZE_W-1:0]    sprite_height;
  logic [1:0]                    align_mode;
  logic                          key_enable;
  logic [csb_pkg::COLOR_W-1:0]   key_color;
  logic [csb_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[csb_pkg::REG_IDX_W+1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x      <= '0;
      origin_y      <= '0;
      sprite_width  <= csb_pkg::SIZE_W'(1);
      sprite_height <= csb_pkg::SIZE_W'(1);
      align_mode    <= csb_pkg::ALIGN_LEFT;
      key_enable    <= 1'b0;
      key_color     <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        csb_pkg::REG_ORIGIN_X:   origin_x      <= pwdata[csb_pkg::POS_W-1:0];
        csb_pkg::REG_ORIGIN_Y:   origin_y      <= pwdata[csb_pkg::POS_W-1:0];
        csb_pkg::REG_WIDTH:      sprite_width  <= pwdata[csb_pkg::SIZE_W-1:0];
        csb_pkg::REG_HEIGHT:     sprite_height <= pwdata[csb_pkg::SIZE_W-1:0];
        csb_pkg::REG_ALIGN:      align_mode    <= pwdata[1:0];
        csb_pkg::REG_KEY_ENABLE: key_enable    <= pwdata[0];
        csb_pkg::REG_KEY_COLOR:  key_color     <= pwdata[csb_pkg::COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      csb_pkg::REG_ORIGIN_X:   prdata = csb_pkg::DATA_W'(origin_x);
      csb_pkg::REG_ORIGIN_Y:   prdata = csb_pkg::DATA_W'(origin_y);
      csb_pkg::REG_WIDTH:      prdata = csb_pkg::DATA_W'(sprite_width);
      csb_pkg::REG_HEIGHT:     prdata = csb_pkg::DATA_W'(sprite_height);
      csb_pkg::REG_ALIGN:      prdata = csb_pkg::DATA_W'(align_mode);
      csb_pkg::REG_KEY_ENABLE: prdata = csb_pkg::DATA_W'(key_enable);
      csb_pkg::REG_KEY_COLOR:  prdata = csb_pkg::DATA_W'(key_color);
      default:                 prdata = '0;
    endcase
  end

  always_comb begin
    cfg.origin_x   = origin_x;
    cfg.origin_y   = origin_y;
    cfg.width_eff  = csb_pkg::eff_size(sprite_width);
    cfg.height_eff = csb_pkg::eff_size(sprite_height);
    cfg.align_mode = align_mode;
    cfg.key_enable = key_enable;
    cfg.key_color  = key_color;
  end

endmodule

FILE: design/csb_cursor.sv
// ----------------------------------------------------------------------------
// csb_cursor
// Column and row counters that walk the sprite in stored order.
// ----------------------------------------------------------------------------
module csb_cursor (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [csb_pkg::SIZE_W-1:0]  width_eff,
  input  logic [csb_pkg::SIZE_W-1:0]  height_eff,
  output csb_pkg::cursor_t            cur
);

  logic [csb_pkg::CNT_W-1:0] column_count;
  logic [csb_pkg::CNT_W-1:0] row_count;
  logic                      row_end;
  logic                      done;

  // A counter at or past the current size also ends its row or the sprite.
  assign row_end = (csb_pkg::CMP_W'(column_count) + csb_pkg::CMP_W'(1))
                   >= csb_pkg::CMP_W'(width_eff);
  assign done    = row_end &&
                   ((csb_pkg::CMP_W'(row_count) + csb_pkg::CMP_W'(1))
                    >= csb_pkg::CMP_W'(height_eff));

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (step) begin
      if (row_end) begin
        column_count <= '0;
        row_count    <= done ? '0 : row_count + csb_pkg::CNT_W'(1);
      end else begin
        column_count <= column_count + csb_pkg::CNT_W'(1);
      end
    end
  end

  assign cur.col  = column_count;
  assign cur.row  = row_count;
  assign cur.done = done;

endmodule

FILE: design/csb_pixel_calc.sv
// ----------------------------------------------------------------------------
// csb_pixel_calc
// Screen placement, clipping, color key test and framebuffer index.
// ----------------------------------------------------------------------------
module csb_pixel_calc (
  input  csb_pkg::cfg_t                cfg,
  input  csb_pkg::cursor_t             cur,
  input  logic [csb_pkg::COLOR_W-1:0]  pix,
  output csb_pkg::result_t             res
);

  logic signed [csb_pkg::CALC_W-1:0] shift;
  logic signed [csb_pkg::CALC_W-1:0] col;
  logic signed [csb_pkg::CALC_W-1:0] line;
  logic                              visible;
  logic                              keyed;
  logic                              we;
  logic [csb_pkg::PROD_W-1:0]        prod;

  always_comb begin
    case (cfg.align_mode)
      csb_pkg::ALIGN_MID: shift = csb_pkg::CALC_W'(cfg.width_eff >> 1);
      csb_pkg::ALIGN_END: shift = csb_pkg::CALC_W'(cfg.width_eff);
      default:            shift = '0;
    endcase
  end

  // Stored rows run bottom-up, so stored row r lands on line y + h - 1 - r.
  assign col  = csb_pkg::CALC_W'(cfg.origin_x) - shift + csb_pkg::CALC_W'(cur.col);
  assign line = csb_pkg::CALC_W'(cfg.origin_y) + csb_pkg::CALC_W'(cfg.height_eff)
                - csb_pkg::CALC_W'(1) - csb_pkg::CALC_W'(cur.row);

  assign visible = !col[csb_pkg::CALC_W-1] && (col < csb_pkg::CALC_W'(csb_pkg::H_RES)) &&
                   !line[csb_pkg::CALC_W-1] && (line < csb_pkg::CALC_W'(csb_pkg::V_RES));
  assign keyed   = cfg.key_enable && (pix == cfg.key_color);
  assign we      = visible && !keyed;

  assign prod = csb_pkg::PROD_W'(line[csb_pkg::LINE_W-1:0]) *
                csb_pkg::PROD_W'(csb_pkg::H_RES) +
                csb_pkg::PROD_W'(col[csb_pkg::COL_W-1:0]);

  assign res.fb_index     = we ? csb_pkg::IDX_W'(prod) : '0;
  assign res.fb_data      = pix;
  assign res.write_enable = we;
  assign res.sprite_done  = cur.done;

endmodule

FILE: design/color_keyed_sprite_blit_unit.sv
// ----------------------------------------------------------------------------
// A request accepted into the input register moves to the result register
// once that is free. Throughput: one pixel per cycle while out_stall is low;
// the input and result registers form a two-entry pipeline, so a new pixel
// is taken while a result waits as long as the input register is empty.
// Reset (rst, synchronous, active high) empties both pipeline stages, clears
// the column and row counters and loads the register reset values.
// ----------------------------------------------------------------------------
// color_keyed_sprite_blit_unit
// Streams sprite pixels to framebuffer writes with alignment, clipping on
// both axes and an optional transparent color key.
// ----------------------------------------------------------------------------
module color_keyed_sprite_blit_unit (
  input  logic                         clk,
  input  logic                         rst,
  // Configuration port.
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [csb_pkg::ADDR_W-1:0]   paddr,
  input  logic [csb_pkg::DATA_W-1:0]   pwdata,
  output logic [csb_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  // Pixel request channel.
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [csb_pkg::COLOR_W-1:0]  pixel_color,
  // Framebuffer write channel.
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [csb_pkg::IDX_W-1:0]    fb_index,
  output logic [csb_pkg::COLOR_W-1:0]  fb_data,
  output logic                         write_enable,
  output logic                         sprite_done
);

  csb_pkg::cfg_t    cfg;
  csb_pkg::cursor_t cur;
  csb_pkg::cursor_t s1_cur;
  csb_pkg::result_t res;

  logic                        s1_valid;
  logic [csb_pkg::COLOR_W-1:0] s1_pix;
  logic                        accept;
  logic                        out_free;
  logic                        advance;

  csb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The cursor names the sprite position of the request being accepted and
  // moves on at the same edge, so each pixel carries its own position.
  csb_cursor u_cursor (
    .clk        (clk),
    .rst        (rst),
    .step       (accept),
    .width_eff  (cfg.width_eff),
    .height_eff (cfg.height_eff),
    .cur        (cur)
  );

  // The result register is free when it is empty or its result leaves now.
  // The input register moves forward whenever the result register is free,
  // and it takes a new request when it is empty or moving forward.
  assign out_free = !out_valid || !out_stall;
  assign advance  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix <= pixel_color;
      s1_cur <= cur;
    end
  end

  // All placement and clip logic sits between the two registers.
  csb_pixel_calc u_calc (
    .cfg (cfg),
    .cur (s1_cur),
    .pix (s1_pix),
    .res (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      fb_index     <= res.fb_index;
      fb_data      <= res.fb_data;
      write_enable <= res.write_enable;
      sprite_done  <= res.sprite_done;
    end
  end

endmodule

FILE: design/csb_checker.sv
// ----------------------------------------------------------------------------
// csb_checker
// Port level checks for the sprite blitter, bound to the top level.
// ----------------------------------------------------------------------------
module csb_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [csb_pkg::IDX_W-1:0]    fb_index,
  input logic [csb_pkg::COLOR_W-1:0]  fb_data,
  input logic                         write_enable,
  input logic                         sprite_done
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(fb_index) && $stable(fb_data) &&
                               $stable(write_enable) && $stable(sprite_done))
    else $error("stalled result changed");

  // Requests are only held off when the output side is full and stalled.
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("request stalled while output could drain");

  // A skipped pixel carries a zero index.
  a_skip_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !write_enable |-> fb_index == '0)
    else $error("skipped pixel has nonzero index");

  // A write lands inside the framebuffer.
  a_on_screen: assert property (@(posedge clk) disable iff (rst)
    out_valid && write_enable |->
      fb_index < csb_pkg::IDX_W'(csb_pkg::H_RES * csb_pkg::V_RES))
    else $error("write outside the framebuffer");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

endmodule

bind color_keyed_sprite_blit_unit csb_checker u_csb_checker (.*);
